@@ src/toy_spn_cipher_32_defines.svh @@
// ----------------------------------------------------------------------------
// toy_spn_cipher_32 assertion macros
// Shared property wrappers for the checker module.
// ----------------------------------------------------------------------------
`ifndef TOY_SPN_CIPHER_32_DEFINES_SVH
`define TOY_SPN_CIPHER_32_DEFINES_SVH

// immediate implication, clocked on clk, off during reset
`define TSPN_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define TSPN_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/tspn32_pkg.sv @@
// ----------------------------------------------------------------------------
// tspn32_pkg
// Tables, codes and helper functions of the 32-bit two-round SPN cipher.
// ----------------------------------------------------------------------------
package tspn32_pkg;

	localparam int BLK_W   = 32;
	localparam int NIB_W   = 4;
	localparam int NIB_N   = BLK_W / NIB_W;
	localparam int SEL_W   = 5;
	localparam int ENC_ROT = 2;
	localparam int DEC_ROT = 30;

	localparam logic OP_ENC = 1'b0;
	localparam logic OP_DEC = 1'b1;

	typedef logic [NIB_W-1:0] sbox_t [16];
	typedef logic [SEL_W-1:0] sel_tbl_t [BLK_W];

	localparam sbox_t SBOX_FWD = '{
		4'd7, 4'd3, 4'd6, 4'd1, 4'd13, 4'd9, 4'd10, 4'd11,
		4'd2, 4'd12, 4'd0, 4'd4, 4'd5, 4'd15, 4'd8, 4'd14
	};

	localparam sbox_t SBOX_INV = '{
		4'd10, 4'd3, 4'd8, 4'd1, 4'd11, 4'd12, 4'd2, 4'd0,
		4'd14, 4'd5, 4'd6, 4'd7, 4'd9, 4'd4, 4'd15, 4'd13
	};

	localparam sel_tbl_t SEL_K0 = '{
		5'd17, 5'd31, 5'd0, 5'd0, 5'd18, 5'd7, 5'd20, 5'd18,
		5'd8, 5'd1, 5'd27, 5'd27, 5'd2, 5'd4, 5'd11, 5'd20,
		5'd25, 5'd13, 5'd17, 5'd10, 5'd24, 5'd9, 5'd29, 5'd15,
		5'd21, 5'd18, 5'd28, 5'd20, 5'd4, 5'd5, 5'd24, 5'd15
	};

	localparam sel_tbl_t SEL_K1 = '{
		5'd15, 5'd2, 5'd5, 5'd0, 5'd13, 5'd31, 5'd5, 5'd10,
		5'd18, 5'd2, 5'd3, 5'd14, 5'd14, 5'd0, 5'd11, 5'd1,
		5'd20, 5'd15, 5'd14, 5'd27, 5'd6, 5'd11, 5'd19, 5'd3,
		5'd6, 5'd20, 5'd14, 5'd2, 5'd28, 5'd11, 5'd5, 5'd8
	};

	localparam sel_tbl_t SEL_K2 = '{
		5'd4, 5'd24, 5'd23, 5'd12, 5'd22, 5'd21, 5'd31, 5'd15,
		5'd29, 5'd1, 5'd0, 5'd26, 5'd17, 5'd24, 5'd16, 5'd5,
		5'd31, 5'd0, 5'd20, 5'd21, 5'd26, 5'd30, 5'd15, 5'd11,
		5'd16, 5'd23, 5'd18, 5'd30, 5'd30, 5'd19, 5'd28, 5'd23
	};

	function automatic logic [BLK_W-1:0] round_key(input logic [BLK_W-1:0] mk,
			input sel_tbl_t sel);
		logic [BLK_W-1:0] k;
		k = '0;
		for (int i = 0; i < BLK_W; i++) begin
			k[i] = mk[sel[i]];
		end
		return k;
	endfunction

	function automatic logic [BLK_W-1:0] nibble_sub(input sbox_t box,
			input logic [BLK_W-1:0] x);
		logic [BLK_W-1:0] r;
		r = '0;
		for (int i = 0; i < NIB_N; i++) begin
			r[i*NIB_W +: NIB_W] = box[x[i*NIB_W +: NIB_W]];
		end
		return r;
	endfunction

	function automatic logic [BLK_W-1:0] ror_enc(input logic [BLK_W-1:0] x);
		return {x[ENC_ROT-1:0], x[BLK_W-1:ENC_ROT]};
	endfunction

	function automatic logic [BLK_W-1:0] ror_dec(input logic [BLK_W-1:0] x);
		return {x[DEC_ROT-1:0], x[BLK_W-1:DEC_ROT]};
	endfunction

endpackage

@@ src/tspn32_core.sv @@
// ----------------------------------------------------------------------------
// tspn32_core
// Key selection and both two-round datapaths, opcode picks the result.
// ----------------------------------------------------------------------------
module tspn32_core
	import tspn32_pkg::*;
(
	input  logic [BLK_W-1:0] master_key,
	input  logic             opcode,
	input  logic [BLK_W-1:0] data_in,
	output logic [BLK_W-1:0] data_out
);

	logic [BLK_W-1:0] k0, k1, k2;
	logic [BLK_W-1:0] enc_r1, enc_r2;
	logic [BLK_W-1:0] dec_r1, dec_r2;

	assign k0 = round_key(master_key, SEL_K0);
	assign k1 = round_key(master_key, SEL_K1);
	assign k2 = round_key(master_key, SEL_K2);

	assign enc_r1 = ror_enc(nibble_sub(SBOX_FWD, data_in ^ k0)) ^ k1;
	assign enc_r2 = ror_enc(nibble_sub(SBOX_FWD, enc_r1)) ^ k2;

	assign dec_r1 = nibble_sub(SBOX_INV, ror_dec(data_in ^ k2));
	assign dec_r2 = nibble_sub(SBOX_INV, ror_dec(dec_r1 ^ k1));

	assign data_out = (opcode == OP_DEC) ? (dec_r2 ^ k0) : enc_r2;

endmodule

@@ src/toy_spn_cipher_32.sv @@
// Path: an accepted beat is registered in data_s1, passes the cipher core and
// is registered in data_s2. Throughput: one block per cycle unless out_stall
// backs up the pipeline; the core sits between the input and output registers.
// Reset: arst_n clears both valid flags and the master key to zero.
// ----------------------------------------------------------------------------
// toy_spn_cipher_32
// Two-round 32-bit SPN cipher with valid/stall channels and a key write port.
// ----------------------------------------------------------------------------
module toy_spn_cipher_32
	import tspn32_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [BLK_W-1:0] cfg_data,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             opcode,
	input  logic [BLK_W-1:0] data_in,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [BLK_W-1:0] data_out
);

	logic [BLK_W-1:0] master_key_q;
	logic             valid_s1;
	logic             opcode_s1;
	logic [BLK_W-1:0] data_s1;
	logic             valid_s2;
	logic [BLK_W-1:0] data_s2;
	logic [BLK_W-1:0] core_out;
	logic             s1_free;
	logic             s2_free;

	assign s2_free   = !valid_s2 || !out_stall;
	assign s1_free   = !valid_s1 || s2_free;
	assign in_stall  = !s1_free;
	assign cfg_ready = !valid_s1;
	assign out_valid = valid_s2;
	assign data_out  = data_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			master_key_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			master_key_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s1_free) begin
				valid_s1 <= in_valid;
			end
			if (s2_free) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && s1_free) begin
			opcode_s1 <= opcode;
			data_s1   <= data_in;
		end
		if (valid_s1 && s2_free) begin
			data_s2 <= core_out;
		end
	end

	tspn32_core u_core (
		.master_key (master_key_q),
		.opcode     (opcode_s1),
		.data_in    (data_s1),
		.data_out   (core_out)
	);

endmodule

@@ src/tspn32_chk.sv @@
// ----------------------------------------------------------------------------
// tspn32_chk
// Port-level checks of the cipher pipeline, bound to the top level.
// ----------------------------------------------------------------------------
`include "toy_spn_cipher_32_defines.svh"

module tspn32_chk
	import tspn32_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_stall,
	input logic             out_valid,
	input logic             out_stall,
	input logic [BLK_W-1:0] data_out
);

	// held output beat
	`TSPN_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(data_out), "stalled beat changed")

	// input backs up only when both stages are full and output is stalled
	`TSPN_ASSERT_IMP(a_stall_full, in_stall, out_valid && out_stall, "input stalled with room")

	// accepted beat is expected at the output after the stage 1 and stage 2 registers
	`TSPN_ASSERT_NXT(a_latency, in_valid && !in_stall, ##1 out_valid, "accepted beat missing at output")

	// no output beat rises without an accepted input beat ahead of it through both stages
	`TSPN_ASSERT_IMP(a_no_phantom, $rose(out_valid), $past(in_valid && !in_stall, 2), "beat without input")

endmodule

bind toy_spn_cipher_32 tspn32_chk u_chk (.*);

@@ bench/tb_toy_spn_cipher_32.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_toy_spn_cipher_32
// Self-checking bench for the two-round 32-bit SPN cipher. An in-bench
// predictor derives the round keys from the current master key and computes
// every encrypt or decrypt result. A scoreboard compares each output beat in
// order. Input and output sides idle at random. Key changes happen between
// drained phases.
// ----------------------------------------------------------------------------
module tb_toy_spn_cipher_32;
	import tspn32_pkg::*;

	localparam int BLOCK_CYCLE_LIMIT = 200000;
	localparam int ENC_SHIFT = 2;
	localparam int DEC_SHIFT = 30;
	localparam int MAX_REPORTS = 10;

	localparam bit [3:0] FWD_BOX [16] = '{
		4'd7, 4'd3, 4'd6, 4'd1, 4'd13, 4'd9, 4'd10, 4'd11,
		4'd2, 4'd12, 4'd0, 4'd4, 4'd5, 4'd15, 4'd8, 4'd14
	};
	localparam bit [3:0] INV_BOX [16] = '{
		4'd10, 4'd3, 4'd8, 4'd1, 4'd11, 4'd12, 4'd2, 4'd0,
		4'd14, 4'd5, 4'd6, 4'd7, 4'd9, 4'd4, 4'd15, 4'd13
	};
	localparam bit [4:0] K0_PICK [32] = '{
		5'd17, 5'd31, 5'd0, 5'd0, 5'd18, 5'd7, 5'd20, 5'd18,
		5'd8, 5'd1, 5'd27, 5'd27, 5'd2, 5'd4, 5'd11, 5'd20,
		5'd25, 5'd13, 5'd17, 5'd10, 5'd24, 5'd9, 5'd29, 5'd15,
		5'd21, 5'd18, 5'd28, 5'd20, 5'd4, 5'd5, 5'd24, 5'd15
	};
	localparam bit [4:0] K1_PICK [32] = '{
		5'd15, 5'd2, 5'd5, 5'd0, 5'd13, 5'd31, 5'd5, 5'd10,
		5'd18, 5'd2, 5'd3, 5'd14, 5'd14, 5'd0, 5'd11, 5'd1,
		5'd20, 5'd15, 5'd14, 5'd27, 5'd6, 5'd11, 5'd19, 5'd3,
		5'd6, 5'd20, 5'd14, 5'd2, 5'd28, 5'd11, 5'd5, 5'd8
	};
	localparam bit [4:0] K2_PICK [32] = '{
		5'd4, 5'd24, 5'd23, 5'd12, 5'd22, 5'd21, 5'd31, 5'd15,
		5'd29, 5'd1, 5'd0, 5'd26, 5'd17, 5'd24, 5'd16, 5'd5,
		5'd31, 5'd0, 5'd20, 5'd21, 5'd26, 5'd30, 5'd15, 5'd11,
		5'd16, 5'd23, 5'd18, 5'd30, 5'd30, 5'd19, 5'd28, 5'd23
	};

	function automatic logic [BLK_W-1:0] pick_key(input logic [BLK_W-1:0] mk,
			input bit [4:0] pick [32]);
		logic [BLK_W-1:0] k;
		for (int i = 0; i < BLK_W; i++) begin
			k[i] = mk[pick[i]];
		end
		return k;
	endfunction

	function automatic logic [BLK_W-1:0] sub_nibbles(input bit [3:0] box [16],
			input logic [BLK_W-1:0] x);
		logic [BLK_W-1:0] r;
		for (int i = 0; i < 8; i++) begin
			r[i*4 +: 4] = box[x[i*4 +: 4]];
		end
		return r;
	endfunction

	function automatic logic [BLK_W-1:0] rotr(input logic [BLK_W-1:0] x,
			input int unsigned n);
		return (x >> n) | (x << (BLK_W - n));
	endfunction

	function automatic logic [BLK_W-1:0] spn_transform(input logic op,
			input logic [BLK_W-1:0] blk, input logic [BLK_W-1:0] mk);
		logic [BLK_W-1:0] k0;
		logic [BLK_W-1:0] k1;
		logic [BLK_W-1:0] k2;
		logic [BLK_W-1:0] x;
		k0 = pick_key(mk, K0_PICK);
		k1 = pick_key(mk, K1_PICK);
		k2 = pick_key(mk, K2_PICK);
		x = blk;
		if (op == OP_ENC) begin
			x = x ^ k0;
			x = rotr(sub_nibbles(FWD_BOX, x), ENC_SHIFT) ^ k1;
			x = rotr(sub_nibbles(FWD_BOX, x), ENC_SHIFT) ^ k2;
		end else begin
			x = sub_nibbles(INV_BOX, rotr(x ^ k2, DEC_SHIFT));
			x = sub_nibbles(INV_BOX, rotr(x ^ k1, DEC_SHIFT));
			x = x ^ k0;
		end
		return x;
	endfunction

	class block_scoreboard;
		logic [BLK_W-1:0] master_key;
		logic [BLK_W-1:0] expected_blocks [$];
		int unsigned n_enc;
		int unsigned n_dec;
		int unsigned n_checked;
		int unsigned n_bad;
		int unsigned n_keys;

		function new();
			master_key = '0;
			n_enc = 0;
			n_dec = 0;
			n_checked = 0;
			n_bad = 0;
			n_keys = 0;
		endfunction

		function void set_key(input logic [BLK_W-1:0] k);
			master_key = k;
			n_keys++;
		endfunction

		function logic [BLK_W-1:0] predict(input logic op, input logic [BLK_W-1:0] blk);
			return spn_transform(op, blk, master_key);
		endfunction

		function void note_block(input logic op, input logic [BLK_W-1:0] blk);
			expected_blocks.insert(expected_blocks.size(), predict(op, blk));
			if (op == OP_ENC) n_enc++;
			else n_dec++;
		endfunction

		function void check_block(input logic [BLK_W-1:0] got);
			logic [BLK_W-1:0] want;
			n_checked++;
			if (expected_blocks.size() == 0) begin
				n_bad++;
				if (n_bad <= MAX_REPORTS)
					$display("unexpected output beat: data_out %08h", got);
			end else begin
				want = expected_blocks.pop_front();
				if (got !== want) begin
					n_bad++;
					if (n_bad <= MAX_REPORTS)
						$display("data_out mismatch on beat %0d: expected %08h, got %08h",
							n_checked, want, got);
				end
			end
		endfunction

		function int pending();
			return expected_blocks.size();
		endfunction
	endclass

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [BLK_W-1:0] cfg_data  = '0;
	logic             in_valid  = 1'b0;
	logic             in_stall;
	logic             opcode    = OP_ENC;
	logic [BLK_W-1:0] data_in   = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic [BLK_W-1:0] data_out;

	block_scoreboard sb = new();
	bit              calm = 1'b0;
	int unsigned     cycles = 0;
	int unsigned     rx_seen = 0;
	int              rx_wait = 0;

	toy_spn_cipher_32 i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.opcode    (opcode),
		.data_in   (data_in),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.data_out  (data_out)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > BLOCK_CYCLE_LIMIT) begin
			$display("tb_toy_spn_cipher_32 failed");
			$finish;
		end
	end

	// output monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_block(data_out);
	end

	// receiver: fresh hold-off after every output beat, random unless calm
	always @(negedge clk) begin
		if (sb.n_checked != rx_seen) begin
			rx_seen = sb.n_checked;
			rx_wait = calm ? 0 : $urandom_range(0, 4);
		end
		if (rx_wait > 0) begin
			out_stall <= 1'b1;
			rx_wait--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// called at a falling edge, returns at a falling edge with the beat taken
	task automatic send_block(input logic op, input logic [BLK_W-1:0] blk);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		opcode   <= op;
		data_in  <= blk;
		do @(posedge clk); while (in_stall);
		sb.note_block(op, blk);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_key(input logic [BLK_W-1:0] k);
		cfg_valid <= 1'b1;
		cfg_data  <= k;
		do @(posedge clk); while (!cfg_ready);
		sb.set_key(k);
		@(negedge clk);
		cfg_valid <= 1'b0;
		cfg_data  <= $urandom;
	endtask

	initial begin
		logic [BLK_W-1:0] blk;
		logic             op;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset key
		send_block(OP_ENC, '0);
		send_block(OP_DEC, '0);
		send_block(OP_ENC, '1);
		send_block(OP_DEC, '1);
		drain();

		write_key('1);
		send_block(OP_ENC, '0);
		send_block(OP_ENC, '1);
		send_block(OP_DEC, '0);
		send_block(OP_DEC, '1);
		send_block(OP_ENC, 32'h5555_5555);
		send_block(OP_DEC, 32'hAAAA_AAAA);
		drain();

		// round trips under a random key
		write_key($urandom);
		blk = $urandom;
		send_block(OP_ENC, blk);
		send_block(OP_DEC, sb.predict(OP_ENC, blk));
		send_block(OP_DEC, blk);
		send_block(OP_ENC, sb.predict(OP_DEC, blk));
		drain();

		write_key(32'h0000_0001);
		send_block(OP_ENC, '0);
		send_block(OP_DEC, '0);
		send_block(OP_ENC, 32'h8000_0000);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			if (ph == 0) write_key('0);
			else if (ph == 1) write_key('1);
			else write_key($urandom);
			calm = (ph == 3);
			for (int i = 0; i < 250; i++) begin
				if (i == 120) drain();
				case ($urandom_range(0, 9))
					0: blk = '0;
					1: blk = '1;
					default: blk = $urandom;
				endcase
				op = 1'($urandom_range(0, 1));
				send_block(op, blk);
			end
			calm = 1'b0;
			drain();
		end

		$display("covered %0d encrypt and %0d decrypt blocks over %0d key settings",
			sb.n_enc, sb.n_dec, sb.n_keys);
		$display("%0d output beats checked, %0d mismatches", sb.n_checked, sb.n_bad);
		if (sb.n_bad == 0 && sb.pending() == 0)
			$display("tb_toy_spn_cipher_32 passed");
		else
			$display("tb_toy_spn_cipher_32 failed");
		$finish;
	end

endmodule
